@@ design/round_robin_process_table_macros.svh @@
// Assertion macros for the round-robin process table.
// Used by rrpt_ctrl; depends on signals clk and rst_n in scope.
`ifndef ROUND_ROBIN_PROCESS_TABLE_MACROS_SVH
`define ROUND_ROBIN_PROCESS_TABLE_MACROS_SVH

// same-cycle implication
`define RRPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RRPT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/rrpt_pkg.sv @@
// Shared constants, codes and controller/datapath interface types.
// No dependencies.
package rrpt_pkg;
  localparam int SLOTS = 16;
  localparam int SW = $clog2(SLOTS);
  localparam int PW = SW + 1;
  localparam logic [PW-1:0] NO_PARENT = PW'(SLOTS);

  localparam logic [2:0] ST_NEW = 3'd0;
  localparam logic [2:0] ST_READY = 3'd1;
  localparam logic [2:0] ST_RUNNING = 3'd2;
  localparam logic [2:0] ST_WAITING = 3'd3;
  localparam logic [2:0] ST_TERM = 3'd4;

  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_CREATE = 3'd1;
  localparam logic [2:0] OP_WAIT = 3'd2;
  localparam logic [2:0] OP_WAKE = 3'd3;
  localparam logic [2:0] OP_TERM = 3'd4;

  localparam logic [2:0] STS_OK = 3'd0;
  localparam logic [2:0] STS_NOTFOUND = 3'd1;
  localparam logic [2:0] STS_REFUSED = 3'd2;
  localparam logic [2:0] STS_FULL = 3'd3;
  localparam logic [2:0] STS_BADPAR = 3'd4;

  localparam logic [7:0] PERIOD_RST = 8'd10;

  typedef struct packed {
    logic       load;
    logic       tick;
    logic       find_step;
    logic       create;
    logic       set_wait;
    logic       set_wake;
    logic       casc_init;
    logic       casc_step;
    logic       apply;
    logic       sw_init;
    logic       sw_step;
    logic       out_load;
    logic       sts_we;
    logic [2:0] sts;
  } rrpt_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] fstate;
    logic       tick_fire;
    logic       any;
    logic       multi;
    logic       pid_zero;
    logic       tid_one;
    logic       found;
    logic       hit;
    logic       k_last;
    logic       free_avail;
    logic       has_running;
    logic       run_term;
    logic       sw_take;
    logic       casc_done;
    logic       out_busy;
  } rrpt_stat_t;
endpackage

@@ design/round_robin_process_table.sv @@
// Round-robin process table: one result word per input word.
// Result valid after accept: decode, then id scan, descendant cascade and switch
// scan, plus post/apply/check/setup/output.
// One word in flight; next word taken the cycle after the result is registered,
// later while a result waits on out_tready.
// Synchronous active-low reset empties the table, sets tick_period to 10.
module round_robin_process_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,     // tick_period
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,      // op[2:0], task_id[18:3], parent_id[34:19]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata      // status[2:0], new_id[18:3], running_id[34:19],
                                     // switched[35]
);
  rrpt_pkg::rrpt_cmd_t  cmd;
  rrpt_pkg::rrpt_stat_t stat;

  rrpt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .stat(stat), .cmd(cmd)
  );

  rrpt_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_word(in_tdata[34:0]), .cmd(cmd), .stat(stat),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );
endmodule

@@ design/rrpt_dp.sv @@
// Datapath: task table, scan counter, cascade marks, tick divider, output word.
// Depends on rrpt_pkg; driven by rrpt_ctrl commands.
module rrpt_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  input  logic [34:0]         in_word,
  input  rrpt_pkg::rrpt_cmd_t cmd,
  output rrpt_pkg::rrpt_stat_t stat,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [39:0]         out_tdata
);
  logic [rrpt_pkg::SLOTS-1:0] valid_r, mark_r, mnext;
  logic [15:0] id_r [rrpt_pkg::SLOTS];
  logic [rrpt_pkg::PW-1:0] par_r [rrpt_pkg::SLOTS];
  logic [2:0] st_r [rrpt_pkg::SLOTS];
  logic [15:0] next_id_r, tid_r, pid_r, newid_r, key;
  logic [rrpt_pkg::SW-1:0] run_r, old_run_r, fslot_r, k_r, offset_r, sw_s, free_slot, free_idx;
  logic has_r, old_has_r, found_r, out_valid_r, free_en;
  logic [7:0] tc_r, period_r, tc_inc, per;
  logic [2:0] op_r, sts_r, ss;
  logic [39:0] out_data_r;
  logic [15:0] nid_inc;

  always_comb begin
    key = (op_r == rrpt_pkg::OP_CREATE) ? pid_r : tid_r;
    tc_inc = tc_r + 8'd1;
    per = (period_r == 8'd0) ? 8'd1 : period_r;
    sw_s = offset_r + k_r;
    ss = st_r[sw_s];
    free_slot = '0;
    stat.free_avail = 1'b0;
    for (int i = rrpt_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        stat.free_avail = 1'b1;
        free_slot = rrpt_pkg::SW'(i);
      end
    end
    for (int i = 0; i < rrpt_pkg::SLOTS; i++) begin
      mnext[i] = mark_r[i];
      if (valid_r[i] && par_r[i] != rrpt_pkg::NO_PARENT && mark_r[par_r[i][rrpt_pkg::SW-1:0]])
        mnext[i] = 1'b1;
    end
    stat.op = op_r;
    stat.fstate = st_r[fslot_r];
    stat.tick_fire = (tc_inc >= per);
    stat.any = |valid_r;
    stat.multi = |(valid_r & (valid_r - rrpt_pkg::SLOTS'(1)));
    stat.pid_zero = (pid_r == 16'd0);
    stat.tid_one = (tid_r == 16'd1);
    stat.found = found_r;
    stat.hit = valid_r[k_r] && (id_r[k_r] == key);
    stat.k_last = (k_r == rrpt_pkg::SW'(rrpt_pkg::SLOTS - 1));
    stat.has_running = has_r;
    stat.run_term = has_r && (st_r[run_r] == rrpt_pkg::ST_TERM);
    stat.sw_take = valid_r[sw_s] && (ss == rrpt_pkg::ST_NEW || ss == rrpt_pkg::ST_READY);
    stat.casc_done = (mnext == mark_r);
    stat.out_busy = out_valid_r && !out_tready;
    free_en = (cmd.sw_init && has_r && valid_r[run_r] && st_r[run_r] == rrpt_pkg::ST_TERM) ||
              (cmd.sw_step && valid_r[sw_s] && ss == rrpt_pkg::ST_TERM);
    free_idx = cmd.sw_init ? run_r : sw_s;
    nid_inc = next_id_r + 16'd1;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      next_id_r <= 16'd1;
      run_r <= '0;
      has_r <= 1'b0;
      tc_r <= 8'd0;
      period_r <= rrpt_pkg::PERIOD_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) period_r <= cfg_wdata;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (cmd.load) begin
        op_r <= in_word[2:0];
        tid_r <= in_word[18:3];
        pid_r <= in_word[34:19];
        old_has_r <= has_r;
        old_run_r <= run_r;
        sts_r <= rrpt_pkg::STS_OK;
        newid_r <= 16'd0;
        found_r <= 1'b0;
        k_r <= '0;
      end
      if (cmd.sts_we) sts_r <= cmd.sts;
      if (cmd.tick) tc_r <= stat.tick_fire ? 8'd0 : tc_inc;
      if (cmd.find_step) begin
        if (stat.hit) begin
          found_r <= 1'b1;
          fslot_r <= k_r;
        end
        k_r <= k_r + rrpt_pkg::SW'(1);
      end
      if (cmd.create) begin
        valid_r[free_slot] <= 1'b1;
        id_r[free_slot] <= next_id_r;
        par_r[free_slot] <= stat.pid_zero ? rrpt_pkg::NO_PARENT : {1'b0, fslot_r};
        st_r[free_slot] <= rrpt_pkg::ST_NEW;
        newid_r <= next_id_r;
        next_id_r <= (nid_inc == 16'd0) ? 16'd1 : nid_inc;
      end
      if (cmd.set_wait) st_r[fslot_r] <= rrpt_pkg::ST_WAITING;
      if (cmd.set_wake && st_r[fslot_r] != rrpt_pkg::ST_RUNNING)
        st_r[fslot_r] <= rrpt_pkg::ST_READY;
      if (cmd.casc_init) mark_r <= rrpt_pkg::SLOTS'(1) << fslot_r;
      if (cmd.casc_step) mark_r <= mnext;
      if (cmd.apply) begin
        for (int i = 0; i < rrpt_pkg::SLOTS; i++)
          if (mark_r[i]) st_r[i] <= rrpt_pkg::ST_TERM;
      end
      if (cmd.sw_init) begin
        if (has_r) begin
          if (valid_r[run_r] && st_r[run_r] == rrpt_pkg::ST_RUNNING)
            st_r[run_r] <= rrpt_pkg::ST_READY;
          offset_r <= run_r + rrpt_pkg::SW'(1);
        end else begin
          offset_r <= '0;
        end
        has_r <= 1'b0;
        k_r <= '0;
      end
      if (cmd.sw_step) begin
        if (stat.sw_take) begin
          st_r[sw_s] <= rrpt_pkg::ST_RUNNING;
          run_r <= sw_s;
          has_r <= 1'b1;
        end
        k_r <= k_r + rrpt_pkg::SW'(1);
      end
      if (free_en) begin
        valid_r[free_idx] <= 1'b0;
        for (int i = 0; i < rrpt_pkg::SLOTS; i++)
          if (valid_r[i] && par_r[i] == {1'b0, free_idx}) par_r[i] <= rrpt_pkg::NO_PARENT;
      end
      if (cmd.out_load) begin
        out_data_r <= {4'd0,
                       (old_has_r != has_r) || (has_r && old_run_r != run_r),
                       has_r ? id_r[run_r] : 16'd0,
                       newid_r, sts_r};
      end
    end
  end
endmodule

@@ design/rrpt_ctrl.sv @@
// Controller state machine sequencing table lookups, cascades and switches.
// Depends on rrpt_pkg and round_robin_process_table_macros.svh.
`include "round_robin_process_table_macros.svh"
module rrpt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  rrpt_pkg::rrpt_stat_t stat,
  output rrpt_pkg::rrpt_cmd_t  cmd
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC = 4'd1;
  localparam logic [3:0] S_FIND = 4'd2;
  localparam logic [3:0] S_POST = 4'd3;
  localparam logic [3:0] S_CREATE = 4'd4;
  localparam logic [3:0] S_CASC = 4'd5;
  localparam logic [3:0] S_APPLY = 4'd6;
  localparam logic [3:0] S_TCHK = 4'd7;
  localparam logic [3:0] S_SWI = 4'd8;
  localparam logic [3:0] S_SWS = 4'd9;
  localparam logic [3:0] S_OUT = 4'd10;

  logic [3:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        case (stat.op)
          rrpt_pkg::OP_TICK: begin
            cmd.tick = 1'b1;
            state_nxt = (stat.tick_fire && stat.any) ? S_SWI : S_OUT;
          end
          rrpt_pkg::OP_CREATE: begin
            if (!stat.pid_zero) state_nxt = S_FIND;
            else if (stat.any) begin
              cmd.sts_we = 1'b1;
              cmd.sts = rrpt_pkg::STS_BADPAR;
              state_nxt = S_OUT;
            end else state_nxt = S_CREATE;
          end
          rrpt_pkg::OP_WAIT, rrpt_pkg::OP_WAKE, rrpt_pkg::OP_TERM: state_nxt = S_FIND;
          default: begin
            cmd.sts_we = 1'b1;
            cmd.sts = rrpt_pkg::STS_REFUSED;
            state_nxt = S_OUT;
          end
        endcase
      end
      S_FIND: begin
        cmd.find_step = 1'b1;
        if (stat.hit || stat.k_last) state_nxt = S_POST;
      end
      S_POST: begin
        state_nxt = S_OUT;
        if (!stat.found) begin
          cmd.sts_we = 1'b1;
          cmd.sts = (stat.op == rrpt_pkg::OP_CREATE) ? rrpt_pkg::STS_BADPAR
                                                     : rrpt_pkg::STS_NOTFOUND;
        end else begin
          case (stat.op)
            rrpt_pkg::OP_CREATE: state_nxt = S_CREATE;
            rrpt_pkg::OP_WAIT, rrpt_pkg::OP_WAKE: begin
              if (stat.fstate == rrpt_pkg::ST_TERM) begin
                cmd.sts_we = 1'b1;
                cmd.sts = rrpt_pkg::STS_REFUSED;
              end else if (stat.op == rrpt_pkg::OP_WAIT) begin
                cmd.set_wait = 1'b1;
                if (stat.has_running) state_nxt = S_SWI;
              end else begin
                cmd.set_wake = 1'b1;
              end
            end
            default: begin
              if (stat.tid_one || !stat.multi) begin
                cmd.sts_we = 1'b1;
                cmd.sts = rrpt_pkg::STS_REFUSED;
              end else begin
                cmd.casc_init = 1'b1;
                state_nxt = S_CASC;
              end
            end
          endcase
        end
      end
      S_CREATE: begin
        if (stat.free_avail) cmd.create = 1'b1;
        else begin
          cmd.sts_we = 1'b1;
          cmd.sts = rrpt_pkg::STS_FULL;
        end
        state_nxt = S_OUT;
      end
      S_CASC: begin
        if (stat.casc_done) state_nxt = S_APPLY;
        else cmd.casc_step = 1'b1;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_TCHK;
      end
      S_TCHK: state_nxt = stat.run_term ? S_SWI : S_OUT;
      S_SWI: begin
        cmd.sw_init = 1'b1;
        state_nxt = S_SWS;
      end
      S_SWS: begin
        cmd.sw_step = 1'b1;
        if (stat.sw_take || stat.k_last) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  `RRPT_ASSERT_NXT(a_accept_dec, in_tvalid && in_tready, state_r == S_DEC, "accept not decoded")
  `RRPT_ASSERT_NOW(a_out_free, cmd.out_load, !stat.out_busy, "result overwrote pending word")
  `RRPT_ASSERT_NXT(a_out_idle, cmd.out_load, state_r == S_IDLE, "no return to idle after result")
endmodule
